// ===== rtl/wcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcf_pkg: shared constants and types for the wolff cluster flip block
// lattice geometry, register codes, reset values and the controller/datapath
// command and status bundles
// ----------------------------------------------------------------------------
package wcf_pkg;

    // lattice side, a power of two so a site index splits into row and column
    localparam int SIDE       = 32;
    localparam int COORD_W    = $clog2(SIDE);
    localparam int SITES      = SIDE * SIDE;
    localparam int SITE_W     = $clog2(SITES);
    localparam int CNT_W      = SITE_W + 1;
    localparam int SIZE_W     = 11;
    localparam int THR_W      = 16;
    localparam int SEED_W     = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 1;

    localparam logic [THR_W-1:0]  THRESH_RESET = 16'd38390;
    localparam logic [SEED_W-1:0] SEED_RESET   = 32'd6432524;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BOND_THRESHOLD = 1'b0,
        CFG_RNG_SEED       = 1'b1
    } t_cfg_addr;

    // neighbor test order: row+1, row-1, col+1, col-1
    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic seed_cap;
        logic seed_flip;
        logic pop;
        logic pop_ld;
        logic nb_rd;
        logic nb_chk;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic func;
        logic stack_empty;
        logic last_dir;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/wcf_rng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcf_rng: bond draw generator
// xorshift32 state plus the bond threshold register; a draw passes when the
// upper half of the advanced state is below the threshold
// ----------------------------------------------------------------------------
module wcf_rng (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wcf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [wcf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_step,
    output logic                          o_pass
);
    import wcf_pkg::*;

    logic [SEED_W-1:0] r_state;
    logic [THR_W-1:0]  r_thr;
    logic [SEED_W-1:0] w_x1;
    logic [SEED_W-1:0] w_x2;
    logic [SEED_W-1:0] n_state;

    assign w_x1    = r_state ^ (r_state << 13);
    assign w_x2    = w_x1 ^ (w_x1 >> 17);
    assign n_state = w_x2 ^ (w_x2 << 5);
    assign o_pass  = n_state[SEED_W-1:SEED_W-THR_W] < r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEED_RESET;
            r_thr   <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_BOND_THRESHOLD: r_thr   <= i_cfg_data[THR_W-1:0];
                CFG_RNG_SEED:       r_state <= i_cfg_data[SEED_W-1:0];
                default: ;
            endcase
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/wcf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcf_dp: cluster datapath
// spin lattice memory, site stack memory, neighbor address logic, counters
// and the result register
// ----------------------------------------------------------------------------
module wcf_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wcf_pkg::t_cmd                 i_cmd,
    output wcf_pkg::t_status              o_status,
    input  logic                          i_func,
    input  logic [wcf_pkg::COORD_W-1:0]   i_row,
    input  logic [wcf_pkg::COORD_W-1:0]   i_col,
    input  logic                          i_cfg_we,
    input  logic [wcf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [wcf_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wcf_pkg::SIZE_W-1:0]    o_cluster_size,
    output logic                          o_spin
);
    import wcf_pkg::*;

    logic              r_spin_mem  [SITES];
    logic [SITE_W-1:0] r_stack_mem [SITES];

    logic              r_spin_rd;
    logic [SITE_W-1:0] r_stack_rd;
    logic              r_func;
    logic [SITE_W-1:0] r_seed;
    logic              r_old;
    logic [SITE_W-1:0] r_cur;
    logic [SITE_W-1:0] r_nb;
    t_dir              r_dir;
    logic [CNT_W-1:0]  r_count;
    logic [SIZE_W-1:0] r_size;
    logic [CNT_W-1:0]  r_clr_cnt;
    logic              r_out_valid;
    logic [SIZE_W-1:0] r_out_size;
    logic              r_out_spin;

    logic [COORD_W-1:0] w_row;
    logic [COORD_W-1:0] w_col;
    logic [COORD_W-1:0] w_row_p;
    logic [COORD_W-1:0] w_row_m;
    logic [COORD_W-1:0] w_col_p;
    logic [COORD_W-1:0] w_col_m;
    logic [SITE_W-1:0]  w_nb;
    logic [SITE_W-1:0]  w_spin_raddr;
    logic               w_spin_we;
    logic [SITE_W-1:0]  w_spin_waddr;
    logic               w_spin_wdata;
    logic               w_stack_we;
    logic [SITE_W-1:0]  w_stack_waddr;
    logic [SITE_W-1:0]  w_stack_wdata;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic               w_match;
    logic               w_pass;
    logic               w_join;
    logic               w_room;

    assign w_row   = r_cur[SITE_W-1:COORD_W];
    assign w_col   = r_cur[COORD_W-1:0];
    // wrap-around comes from the power-of-two side
    assign w_row_p = w_row + COORD_W'(1);
    assign w_row_m = w_row - COORD_W'(1);
    assign w_col_p = w_col + COORD_W'(1);
    assign w_col_m = w_col - COORD_W'(1);

    always_comb begin
        unique case (r_dir)
            DIR_DOWN:  w_nb = {w_row_p, w_col};
            DIR_UP:    w_nb = {w_row_m, w_col};
            DIR_RIGHT: w_nb = {w_row, w_col_p};
            DIR_LEFT:  w_nb = {w_row, w_col_m};
            default:   w_nb = r_cur;
        endcase
    end

    wcf_rng u_rng (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_match),
        .o_pass     (w_pass)
    );

    // only a neighbor still holding the old spin draws a number
    assign w_match  = i_cmd.nb_chk && (r_spin_rd == r_old);
    assign w_join   = w_match && w_pass;
    assign w_room   = r_count < CNT_W'(SITES);
    assign w_cnt_m1 = r_count - CNT_W'(1);

    assign w_spin_raddr = i_cmd.nb_rd ? w_nb : r_seed;

    always_comb begin
        w_spin_we    = 1'b0;
        w_spin_waddr = r_nb;
        w_spin_wdata = ~r_old;
        if (i_cmd.clr_step) begin
            w_spin_we    = 1'b1;
            w_spin_waddr = r_clr_cnt[SITE_W-1:0];
            w_spin_wdata = 1'b1;
        end else if (i_cmd.seed_flip) begin
            w_spin_we    = 1'b1;
            w_spin_waddr = r_seed;
            w_spin_wdata = ~r_spin_rd;
        end else if (w_join) begin
            w_spin_we    = 1'b1;
        end
    end

    always_comb begin
        w_stack_we    = 1'b0;
        w_stack_waddr = r_count[SITE_W-1:0];
        w_stack_wdata = r_nb;
        if (i_cmd.seed_flip) begin
            w_stack_we    = 1'b1;
            w_stack_waddr = '0;
            w_stack_wdata = r_seed;
        end else if (w_join && w_room) begin
            w_stack_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_spin_we) begin
            r_spin_mem[w_spin_waddr] <= w_spin_wdata;
        end
        r_spin_rd <= r_spin_mem[w_spin_raddr];
    end

    // top of stack is read every cycle into a register, which pop_ld loads after a pop
    always_ff @(posedge i_clk) begin
        if (w_stack_we) begin
            r_stack_mem[w_stack_waddr] <= w_stack_wdata;
        end
        r_stack_rd <= r_stack_mem[w_cnt_m1[SITE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_dir       <= DIR_DOWN;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + CNT_W'(1);
            end
            if (i_cmd.seed_flip) begin
                r_count <= CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= w_cnt_m1;
            end else if (w_join && w_room) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.pop_ld) begin
                r_dir <= DIR_DOWN;
            end else if (i_cmd.nb_chk) begin
                r_dir <= t_dir'(r_dir + 2'd1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func <= i_func;
            r_seed <= {i_row, i_col};
            r_size <= '0;
        end else if (i_cmd.seed_flip) begin
            r_size <= SIZE_W'(1);
        end else if (w_join) begin
            r_size <= r_size + SIZE_W'(1);
        end
        if (i_cmd.seed_cap) begin
            r_old <= r_spin_rd;
        end
        if (i_cmd.pop_ld) begin
            r_cur <= r_stack_rd;
        end
        if (i_cmd.nb_rd) begin
            r_nb <= w_nb;
        end
        if (i_cmd.out_load) begin
            r_out_size <= r_size;
            r_out_spin <= r_func ? r_old : ~r_old;
        end
    end

    assign o_status.clr_done    = r_clr_cnt[SITE_W];
    assign o_status.func        = r_func;
    assign o_status.stack_empty = (r_count == '0);
    assign o_status.last_dir    = (r_dir == DIR_LEFT);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_cluster_size = r_out_size;
    assign o_spin         = r_out_spin;

endmodule

// ===== rtl/wcf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcf_ctrl: cluster growth sequencer
// clears the lattice after reset, then walks seed read and, for a flip, stack
// pops and the four neighbor tests of every popped site
// ----------------------------------------------------------------------------
module wcf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  wcf_pkg::t_status i_status,
    output wcf_pkg::t_cmd    o_cmd
);
    import wcf_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SEED_RD,
        S_SEED_WT,
        S_POP,
        S_POP_WT,
        S_NB_RD,
        S_NB_CHK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = !i_status.clr_done;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load_item = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SEED_RD;
                end
            end
            S_SEED_RD: begin
                n_state = S_SEED_WT;
            end
            S_SEED_WT: begin
                o_cmd.seed_cap  = 1'b1;
                o_cmd.seed_flip = !i_status.func;
                n_state = i_status.func ? S_DONE : S_POP;
            end
            S_POP: begin
                if (i_status.stack_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_POP_WT;
                end
            end
            S_POP_WT: begin
                o_cmd.pop_ld = 1'b1;
                n_state      = S_NB_RD;
            end
            S_NB_RD: begin
                o_cmd.nb_rd = 1'b1;
                n_state     = S_NB_CHK;
            end
            S_NB_CHK: begin
                o_cmd.nb_chk = 1'b1;
                n_state = i_status.last_dir ? S_POP : S_NB_RD;
            end
            S_DONE: begin
                o_cmd.out_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/wolff_cluster_flip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wolff_cluster_flip: wolff single-cluster update on a periodic ising lattice
// keeps the spin lattice, grows and flips a cluster per flip request and
// returns single spins on read requests
// ----------------------------------------------------------------------------
// after reset a clearing pass writes +1 to all 1024 sites, with
//   no request taken; configuration writes are taken throughout
// read request: the seed read and seed wait states, then the result state
// flip request: each popped site passes the pop and pop-wait states, and each
//   neighbor test passes the neighbor read and check states
// one request at a time; the result register lets the next request in while a result waits
module wolff_cluster_flip (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // row[4:0], col[9:5], zero fill
    input  logic [0:0]                     s_axis_tuser,  // func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,  // cluster_size[10:0], spin[11], zero fill
    input  logic                           i_cfg_we,
    input  logic [wcf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [wcf_pkg::CFG_W-1:0]      i_cfg_data
);
    import wcf_pkg::*;

    t_cmd              w_cmd;
    t_status           w_status;
    logic [SIZE_W-1:0] w_size;
    logic              w_spin;

    wcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wcf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_func         (s_axis_tuser[0]),
        .i_row          (s_axis_tdata[COORD_W-1:0]),
        .i_col          (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_cluster_size (w_size),
        .o_spin         (w_spin)
    );

    assign m_axis_tdata = {4'b0000, w_spin, w_size};

endmodule
